[design/assert_macros.svh]
// Assertion macros included by rtc_bcd_to_epoch_seconds.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/rtcep_pkg.sv]
package rtcep_pkg;

  // Field and result widths.
  localparam int unsigned BcdW   = 8;
  localparam int unsigned ValW   = 8;
  localparam int unsigned YearsW = 7;
  localparam int unsigned DaysW  = 17;
  localparam int unsigned TodW   = 20;
  localparam int unsigned SecsW  = 32;
  localparam int unsigned YdayW  = 9;
  localparam int unsigned WdayW  = 7;

  // Calendar constants.
  localparam logic [ValW-1:0]   YearBase    = 8'd70;
  localparam logic [ValW-1:0]   YearWrap    = 8'd30;
  localparam logic [ValW-1:0]   MonthMax    = 8'd12;
  localparam logic [ValW-1:0]   MdayMax     = 8'd31;
  localparam logic [DaysW-1:0]  DaysPerYear = 17'd365;
  localparam logic [TodW-1:0]   SecsHour    = 20'd3600;
  localparam logic [TodW-1:0]   SecsMin     = 20'd60;
  localparam logic [DaysW-1:0]  SecsDay     = 17'd86400;
  localparam logic [YdayW-1:0]  FebEnd      = 9'd2;

  typedef logic [YdayW-1:0] yday_t;

  // Days before the first of each month, February counted as 29 days.
  localparam yday_t DaysBefore [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // Decode two BCD digits; nibbles above nine keep their binary weight.
  function automatic logic [ValW-1:0] bcd_decode(input logic [BcdW-1:0] v);
    logic [ValW-1:0] hi;
    logic [ValW-1:0] lo;
    hi = {4'd0, v[7:4]};
    lo = {4'd0, v[3:0]};
    return ValW'((hi << 3) + (hi << 1) + lo);
  endfunction

  // True if either digit is not a decimal digit.
  function automatic logic bcd_bad(input logic [BcdW-1:0] v);
    return (v[7:4] > 4'd9) || (v[3:0] > 4'd9);
  endfunction

endpackage

[design/rtc_bcd_to_epoch_seconds.sv]
// Channel   Handshake                 Payload
// input     start_i, busy_o           second/minute/hour/weekday/day/month/year_bcd_i
// result    result_valid_o (strobe)   epoch_seconds_o, day_of_year_o, weekday_o, fields_bad_o
//
// Three register stages: input register, decode/day-count register, result register.
// An item taken into the input register passes through the decode/day-count register
// to the result register, which drives the result_valid_o strobe.
// No stage ever waits, so one item can be taken every cycle.
// busy_o is always low; results cannot be held off and leave in order.
// rst_ni clears the valid pipeline only; payload registers are not reset.
`include "assert_macros.svh"

module rtc_bcd_to_epoch_seconds (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [rtcep_pkg::BcdW-1:0]     second_bcd_i,
  input  logic [rtcep_pkg::BcdW-1:0]     minute_bcd_i,
  input  logic [rtcep_pkg::BcdW-1:0]     hour_bcd_i,
  input  logic [rtcep_pkg::BcdW-1:0]     weekday_bcd_i,
  input  logic [rtcep_pkg::BcdW-1:0]     day_bcd_i,
  input  logic [rtcep_pkg::BcdW-1:0]     month_bcd_i,
  input  logic [rtcep_pkg::BcdW-1:0]     year_bcd_i,
  output logic                           result_valid_o,
  output logic [rtcep_pkg::SecsW-1:0]    epoch_seconds_o,
  output logic [rtcep_pkg::YdayW-1:0]    day_of_year_o,
  output logic [rtcep_pkg::WdayW-1:0]    weekday_o,
  output logic                           fields_bad_o
);
  import rtcep_pkg::*;

  // Stage 1: raw snapshot.
  logic            in_valid_q;
  logic [BcdW-1:0] sec_q, min_q, hour_q, wday_q, mday_q, mon_q, year_q;

  // Stage 2: day count and time of day.
  logic             mid_valid_q;
  logic [DaysW-1:0] days_q, days_d;
  logic [TodW-1:0]  tod_q, tod_d;
  yday_t            yday_q, yday_d;
  logic [WdayW-1:0] wday_mid_q, wday_mid_d;
  logic             bad_q, bad_d;

  // Stage 3: result.
  logic             out_valid_q;
  logic [SecsW-1:0] secs_q, secs_d;
  yday_t            yday_out_q;
  logic [WdayW-1:0] wday_out_q;
  logic             bad_out_q;

  // Decoded fields.
  logic [ValW-1:0]   sec_v, min_v, hour_v, wday_v, mday_v, mon_v, year_v;
  logic [YearsW-1:0] years;
  logic              month_ok;
  logic              not_leap;
  logic [YearsW-1:0] years_p2;
  yday_t             prior_days;

  // The block never stalls its source.
  assign busy_o = 1'b0;

  // Valid pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= start_i && !busy_o;
      mid_valid_q <= in_valid_q;
      out_valid_q <= mid_valid_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      sec_q  <= second_bcd_i;
      min_q  <= minute_bcd_i;
      hour_q <= hour_bcd_i;
      wday_q <= weekday_bcd_i;
      mday_q <= day_bcd_i;
      mon_q  <= month_bcd_i;
      year_q <= year_bcd_i;
    end
  end

  // Decode the snapshot and count whole days since the epoch, plus one.
  always_comb begin
    sec_v  = bcd_decode(sec_q);
    min_v  = bcd_decode(min_q);
    hour_v = bcd_decode(hour_q);
    wday_v = bcd_decode(wday_q);
    mday_v = bcd_decode(mday_q);
    mon_v  = bcd_decode(mon_q);
    year_v = bcd_decode(year_q);

    years    = (year_v >= YearBase) ? YearsW'(year_v - YearBase)
                                    : YearsW'(year_v + YearWrap);
    years_p2 = years + 7'd2;
    not_leap = (years_p2[1:0] != 2'd0);
    month_ok = (mon_v >= 8'd1) && (mon_v <= MonthMax);

    prior_days = '0;
    if (month_ok) begin
      prior_days = DaysBefore[4'(mon_v - 8'd1)];
      if ((YdayW'(mon_v) > FebEnd) && not_leap) begin
        prior_days = prior_days - 9'd1;
      end
    end

    bad_d = bcd_bad(sec_q) || bcd_bad(min_q) || bcd_bad(hour_q) || bcd_bad(wday_q)
         || bcd_bad(mday_q) || bcd_bad(mon_q) || bcd_bad(year_q)
         || !month_ok || (mday_v < 8'd1) || (mday_v > MdayMax);

    days_d = DaysW'(DaysPerYear * DaysW'(years))
           + DaysW'((years + 7'd1) >> 2)
           + DaysW'(prior_days)
           + DaysW'(mday_v);
    tod_d  = TodW'(SecsHour * TodW'(hour_v)) + TodW'(SecsMin * TodW'(min_v))
           + TodW'(sec_v);
    yday_d     = prior_days + YdayW'(mday_v);
    wday_mid_d = wday_v[WdayW-1:0];
  end

  always_ff @(posedge clk_i) begin
    days_q     <= days_d;
    tod_q      <= tod_d;
    yday_q     <= yday_d;
    wday_mid_q <= wday_mid_d;
    bad_q      <= bad_d;
  end

  // Scale days to seconds; the extra day counted above is taken off here, modulo 2^32.
  always_comb begin
    secs_d = SecsW'({17'd0, SecsDay} * {17'd0, days_q})
           + SecsW'(tod_q)
           - SecsW'(SecsDay);
  end

  always_ff @(posedge clk_i) begin
    secs_q     <= secs_d;
    yday_out_q <= yday_q;
    wday_out_q <= wday_mid_q;
    bad_out_q  <= bad_q;
  end

  assign result_valid_o  = out_valid_q;
  assign epoch_seconds_o = secs_q;
  assign day_of_year_o   = yday_out_q;
  assign weekday_o       = wday_out_q;
  assign fields_bad_o    = bad_out_q;

  // Every result traces back to an item taken at the input.
  `ASSERT_IMPL(a_result_from_item, clk_i, rst_ni, result_valid_o, $past(start_i && !busy_o, 3))
  // An item held in the input register moves on to the middle stage.
  `ASSERT_NEXT(a_item_to_mid, clk_i, rst_ni, in_valid_q, mid_valid_q)
  // A clean date always lands on a legal day of the year.
  `ASSERT_IMPL(a_yday_range, clk_i, rst_ni, result_valid_o && !fields_bad_o,
               (day_of_year_o >= 9'd1) && (day_of_year_o <= 9'd366))

endmodule
